@@ rtl/ssrf_pkg.sv @@
// Package for the stream search-and-replace filter.
// Holds widths, constants, the command carried from front to back, and helpers.
// No dependencies.
`default_nettype none

package ssrf_pkg;

  localparam int MAX_PATTERN_LEN = 8;
  localparam int TEXT_W          = 64;
  localparam int LEN_W           = 4;
  localparam int QUEUE_DEPTH     = 4;
  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  localparam logic [1:0] REG_SEARCH_TEXT  = 2'd0;
  localparam logic [1:0] REG_SEARCH_LEN   = 2'd1;
  localparam logic [1:0] REG_REPLACE_TEXT = 2'd2;
  localparam logic [1:0] REG_REPLACE_LEN  = 2'd3;

  typedef enum logic {
    SRC_SEARCH  = 1'b0,
    SRC_REPLACE = 1'b1
  } src_t;

  // One work command: cnt bytes of the selected text, then optionally one literal byte.
  typedef struct packed {
    src_t             src;
    logic [LEN_W-1:0] cnt;
    logic             has_byte;
    logic [7:0]       data;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
    return (len > LEN_W'(MAX_PATTERN_LEN)) ? LEN_W'(MAX_PATTERN_LEN) : len;
  endfunction

  function automatic logic [7:0] byte_at(input logic [TEXT_W-1:0] text, input logic [2:0] idx);
    return text[8*idx +: 8];
  endfunction

endpackage

`default_nettype wire

@@ rtl/ssrf_in_if.sv @@
// Input channel of the filter: valid/ready handshake with op and in_byte.
// No dependencies.
`default_nettype none

interface ssrf_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] in_byte;

  modport source (output valid, output op, output in_byte, input ready);
  modport sink   (input valid, input op, input in_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/ssrf_out_if.sv @@
// Output channel of the filter: valid/ready handshake with out_byte and last.
// No dependencies.
`default_nettype none

interface ssrf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/ssrf_front.sv @@
// Front end: accepts input transfers, tracks match and line state, and turns
// each item into at most one command for the back end. Depends on ssrf_pkg, ssrf_in_if.
`default_nettype none

module ssrf_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  ssrf_in_if.sink                            in_ch,
  input  wire logic                          cfg_we,
  input  wire logic [ssrf_pkg::TEXT_W-1:0]   search_text,
  input  wire logic [ssrf_pkg::LEN_W-1:0]    search_len,
  input  wire logic [ssrf_pkg::LEN_W-1:0]    replace_len,
  input  wire logic                          q_full,
  output ssrf_pkg::cmd_t                     push_cmd,
  output logic                               push
);
  import ssrf_pkg::*;

  logic [LEN_W-1:0] match_count, match_count_next;
  logic             at_line_start, at_line_start_next;
  logic [LEN_W-1:0] slen, rlen, mc_eff, mc_inc;
  logic             accept;
  cmd_t             cmd;

  assign slen   = eff_len(search_len);
  assign rlen   = eff_len(replace_len);
  assign mc_eff = (match_count >= slen) ? '0 : match_count;
  assign mc_inc = mc_eff + LEN_W'(1);

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  always_comb begin
    cmd                = '{src: SRC_SEARCH, cnt: '0, has_byte: 1'b0, data: in_ch.in_byte};
    match_count_next   = mc_eff;
    at_line_start_next = at_line_start;
    if (in_ch.op) begin
      cmd.cnt          = mc_eff;
      match_count_next = '0;
    end else if (slen == '0) begin
      cmd.src            = SRC_REPLACE;
      cmd.cnt            = at_line_start ? rlen : '0;
      cmd.has_byte       = 1'b1;
      at_line_start_next = (in_ch.in_byte == NEWLINE_BYTE);
    end else if (in_ch.in_byte == byte_at(search_text, mc_eff[2:0])) begin
      if (mc_inc == slen) begin
        cmd.src          = SRC_REPLACE;
        cmd.cnt          = rlen;
        match_count_next = '0;
      end else begin
        match_count_next = mc_inc;
      end
    end else begin
      // partial match is flushed; the mismatching byte does not restart a match
      cmd.cnt          = mc_eff;
      cmd.has_byte     = 1'b1;
      match_count_next = '0;
    end
  end

  assign push_cmd = cmd;
  assign push     = accept && ((cmd.cnt != '0) || cmd.has_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      match_count   <= '0;
      at_line_start <= 1'b1;
    end else if (cfg_we) begin
      match_count   <= '0;
    end else if (accept) begin
      match_count   <= match_count_next;
      at_line_start <= at_line_start_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ssrf_queue.sv @@
// Short command queue between front and back end.
// Depends on ssrf_pkg.
`default_nettype none

module ssrf_queue #(
  parameter int DEPTH = ssrf_pkg::QUEUE_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  ssrf_pkg::cmd_t push_cmd,
  input  wire logic     pop,
  output logic          full,
  output ssrf_pkg::q_head_t head
);
  import ssrf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign do_push    = push && !full;
  assign do_pop     = pop && (count != '0);
  assign head.valid = (count != '0);
  assign head.cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/ssrf_back.sv @@
// Back end: expands the head command into output bytes, one per cycle while out_ch is not
// stalled, into an output register. Depends on ssrf_pkg, ssrf_out_if.
`default_nettype none

module ssrf_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [ssrf_pkg::TEXT_W-1:0] search_text,
  input  wire logic [ssrf_pkg::TEXT_W-1:0] replace_text,
  input  ssrf_pkg::q_head_t                head,
  output logic                             pop,
  ssrf_out_if.source                       out_ch
);
  import ssrf_pkg::*;

  logic [LEN_W-1:0] idx;
  logic [LEN_W-1:0] total;
  logic             step, final_byte;
  logic [7:0]       next_byte;
  logic             out_valid;
  logic [7:0]       out_byte;
  logic             out_last;

  assign total      = head.cmd.cnt + LEN_W'(head.cmd.has_byte);
  assign final_byte = ((idx + LEN_W'(1)) == total);
  assign step       = head.valid && (!out_valid || out_ch.ready);
  assign pop        = step && final_byte;

  always_comb begin
    if (idx < head.cmd.cnt) begin
      next_byte = (head.cmd.src == SRC_REPLACE) ? byte_at(replace_text, idx[2:0])
                                                : byte_at(search_text, idx[2:0]);
    end else begin
      next_byte = head.cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        idx       <= final_byte ? '0 : idx + LEN_W'(1);
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_byte <= next_byte;
      out_last <= final_byte;
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.out_byte = out_byte;
  assign out_ch.last     = out_last;

endmodule

`default_nettype wire

@@ rtl/stream_search_replace_filter_core.sv @@
// Stream search-and-replace filter, top level.
// Input channel in_ch carries op (0 data byte, 1 end-of-stream flush) and in_byte;
// output channel out_ch carries out_byte and last, set on the final byte an item causes.
// Both use valid/ready; a transfer happens on a clock edge with both high.
// Registers are written through cfg_we/cfg_index/cfg_wdata (0 search_text,
// 1 search_len, 2 replace_text, 3 replace_len); any write drops a partial match.
// Search mode replaces the search text; a mismatching byte ends a partial match and is
// not retried as a start. With search_len zero the replacement precedes every line.
// An item's first byte passes through the command queue and then the back end's output
// register before it appears on out_ch.
// Throughput: one item per cycle while items cause at most one byte and out_ch.ready
// stays high; the back end emits one byte per cycle unless stalled, and the command
// queue (QUEUE_DEPTH entries) absorbs multi-byte bursts before in_ch.ready drops.
// A stalled receiver holds the output register; the back end then waits and the
// queue fills, after which in_ch.ready goes low.
// Synchronous reset clears the configuration registers, the queue, the match count and
// the output valid flag, and marks the stream as at the start of a line.
// Depends on ssrf_pkg, ssrf_in_if, ssrf_out_if, ssrf_front, ssrf_queue, ssrf_back.
`default_nettype none

module stream_search_replace_filter_core #(
  parameter int QUEUE_DEPTH = ssrf_pkg::QUEUE_DEPTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  ssrf_in_if.sink                          in_ch,
  ssrf_out_if.source                       out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [ssrf_pkg::TEXT_W-1:0] cfg_wdata
);
  import ssrf_pkg::*;

  logic [TEXT_W-1:0] search_text, replace_text;
  logic [LEN_W-1:0]  search_len, replace_len;
  cmd_t              push_cmd;
  logic              push, pop, q_full;
  q_head_t           head;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_text  <= '0;
      search_len   <= '0;
      replace_text <= '0;
      replace_len  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEARCH_TEXT:  search_text  <= cfg_wdata;
        REG_SEARCH_LEN:   search_len   <= cfg_wdata[LEN_W-1:0];
        REG_REPLACE_TEXT: replace_text <= cfg_wdata;
        REG_REPLACE_LEN:  replace_len  <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  ssrf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .cfg_we      (cfg_we),
    .search_text (search_text),
    .search_len  (search_len),
    .replace_len (replace_len),
    .q_full      (q_full),
    .push_cmd    (push_cmd),
    .push        (push)
  );

  ssrf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (q_full),
    .head     (head)
  );

  ssrf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .search_text  (search_text),
    .replace_text (replace_text),
    .head         (head),
    .pop          (pop),
    .out_ch       (out_ch)
  );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking bench for stream_search_replace_filter_core: search, replace and line-prefix
// behavior checked byte by byte against an in-bench model, with random stalls on both channels.
// Depends on ssrf_pkg, ssrf_in_if, ssrf_out_if and the filter RTL.
module testbench;
  import ssrf_pkg::*;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 10;
  localparam int IDLE_LIMIT    = 4000;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } stream_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } out_beat_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [TEXT_W-1:0] cfg_wdata;

  ssrf_in_if  in_ch();
  ssrf_out_if out_ch();

  stream_search_replace_filter_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // model state
  logic [TEXT_W-1:0] cur_search_text;
  logic [TEXT_W-1:0] cur_replace_text;
  logic [LEN_W-1:0]  cur_search_len;
  logic [LEN_W-1:0]  cur_replace_len;
  logic [LEN_W-1:0]  cur_matched;
  logic              cur_line_start;

  stream_item_t stream_q[$];
  out_beat_t    filtered_q[$];
  stream_item_t next_item;

  logic in_xfer;
  logic out_xfer;
  logic burst_mode;
  logic hold_req;
  int   hold_left;
  int   in_gap;
  int   out_gap;
  int   idle_cycles;
  int   errors;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int clip_len(input logic [LEN_W-1:0] len);
    return (len > LEN_W'(MAX_PATTERN_LEN)) ? MAX_PATTERN_LEN : int'(len);
  endfunction

  function automatic logic [7:0] text_byte(input logic [TEXT_W-1:0] text, input int idx);
    return text[8*idx +: 8];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // expected output bytes for one accepted item
  task automatic apply_filter(input logic op, input logic [7:0] data);
    int         slen;
    int         rlen;
    logic [7:0] emitted[$];
    out_beat_t  beat;
    slen = clip_len(cur_search_len);
    rlen = clip_len(cur_replace_len);
    if (int'(cur_matched) >= slen) cur_matched = '0;
    if (op == OP_END) begin
      for (int i = 0; i < int'(cur_matched); i++) emitted.push_back(text_byte(cur_search_text, i));
      cur_matched = '0;
    end else if (slen == 0) begin
      if (cur_line_start) begin
        for (int i = 0; i < rlen; i++) emitted.push_back(text_byte(cur_replace_text, i));
      end
      emitted.push_back(data);
      cur_line_start = (data == NEWLINE_BYTE);
    end else if (data == text_byte(cur_search_text, int'(cur_matched))) begin
      cur_matched = cur_matched + 1'b1;
      if (int'(cur_matched) == slen) begin
        cur_matched = '0;
        for (int i = 0; i < rlen; i++) emitted.push_back(text_byte(cur_replace_text, i));
      end
    end else begin
      // flush partial match, mismatching byte goes out as is
      for (int i = 0; i < int'(cur_matched); i++) emitted.push_back(text_byte(cur_search_text, i));
      cur_matched = '0;
      emitted.push_back(data);
    end
    foreach (emitted[i]) begin
      beat.data    = emitted[i];
      beat.is_last = (i == emitted.size() - 1);
      filtered_q.push_back(beat);
    end
  endtask

  // only called while the filter is idle; returns at a rising edge
  task automatic write_reg(input logic [1:0] idx, input logic [TEXT_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_SEARCH_TEXT:  cur_search_text  = val;
      REG_SEARCH_LEN:   cur_search_len   = val[LEN_W-1:0];
      REG_REPLACE_TEXT: cur_replace_text = val;
      REG_REPLACE_LEN:  cur_replace_len  = val[LEN_W-1:0];
      default: ;
    endcase
    cur_matched = '0;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_item(input logic op, input logic [7:0] data);
    stream_item_t it;
    it.op   = op;
    it.data = data;
    stream_q.push_back(it);
  endtask

  // wait until every item is in and every byte is out, then let the pipeline settle
  task automatic drain();
    @(posedge clk);
    while (stream_q.size() != 0 || in_ch.valid || filtered_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input int n_items, input logic [LEN_W-1:0] slen_w,
                              input logic [LEN_W-1:0] rlen_w, input logic [TEXT_W-1:0] stext,
                              input logic [TEXT_W-1:0] rtext, input logic squeeze);
    int count;
    int slen;
    int k;
    int r;
    int pattern_th;
    int end_th;
    int nl_th;
    write_reg(REG_SEARCH_TEXT, stext);
    write_reg(REG_SEARCH_LEN, TEXT_W'(slen_w));
    write_reg(REG_REPLACE_TEXT, rtext);
    write_reg(REG_REPLACE_LEN, TEXT_W'(rlen_w));
    slen       = clip_len(slen_w);
    pattern_th = (slen > 0) ? 55 : 0;
    end_th     = (slen > 0) ? 65 : 8;
    nl_th      = (slen > 0) ? 72 : 25;
    if (squeeze) begin
      burst_mode = 1'b1;
      hold_req   = 1'b1;
    end
    count = 0;
    while (count < n_items) begin
      r = $urandom_range(0, 99);
      if (r < pattern_th) begin
        // leading part or all of the search text
        k = $urandom_range(1, slen);
        for (int i = 0; i < k; i++) push_item(OP_DATA, text_byte(stext, i));
        count += k;
      end else if (r < end_th) begin
        push_item(OP_END, 8'($urandom));
        if (slen > 0) count++;
      end else if (r < nl_th) begin
        push_item(OP_DATA, NEWLINE_BYTE);
        count++;
      end else begin
        push_item(OP_DATA, 8'($urandom));
        count++;
      end
    end
    drain();
    burst_mode = 1'b0;
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid   <= 1'b0;
      in_ch.op      <= OP_DATA;
      in_ch.in_byte <= 8'h00;
    end else if (!in_ch.valid || in_xfer) begin
      if (in_xfer && !burst_mode) in_gap = pick_gap();
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (stream_q.size() != 0) begin
        next_item      = stream_q.pop_front();
        in_ch.valid   <= 1'b1;
        in_ch.op      <= next_item.op;
        in_ch.in_byte <= next_item.data;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // output receiver
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req   = 1'b0;
      hold_left  = HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (out_xfer && !burst_mode) out_gap = pick_gap();
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk) begin
    out_beat_t want;
    in_xfer  = !rst && in_ch.valid && in_ch.ready;
    out_xfer = !rst && out_ch.valid && out_ch.ready;
    if (in_xfer) apply_filter(in_ch.op, in_ch.in_byte);
    if (out_xfer) begin
      if (filtered_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected output: expected none, got byte %h last %b",
                 $time, out_ch.out_byte, out_ch.last);
      end else begin
        want = filtered_q.pop_front();
        if (out_ch.out_byte !== want.data || out_ch.last !== want.is_last) begin
          errors++;
          $display("%0t: output mismatch: expected byte %h last %b, got byte %h last %b",
                   $time, want.data, want.is_last, out_ch.out_byte, out_ch.last);
        end
      end
    end
    if (in_xfer || out_xfer) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_SEARCH_TEXT;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.op      = OP_DATA;
    in_ch.in_byte = 8'h00;
    out_ch.ready  = 1'b0;
    in_xfer       = 1'b0;
    out_xfer      = 1'b0;
    burst_mode    = 1'b0;
    hold_req      = 1'b0;
    hold_left     = 0;
    in_gap        = 0;
    out_gap       = 0;
    idle_cycles   = 0;
    errors        = 0;
    cur_search_text  = '0;
    cur_replace_text = '0;
    cur_search_len   = '0;
    cur_replace_len  = '0;
    cur_matched      = '0;
    cur_line_start   = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // search "abc" -> "XY": match, multi-byte flush, no recheck, flush on end
    write_reg(REG_SEARCH_TEXT, 64'h636261);
    write_reg(REG_SEARCH_LEN, 3);
    write_reg(REG_REPLACE_TEXT, 64'h5958);
    write_reg(REG_REPLACE_LEN, 2);
    push_item(OP_DATA, "a"); push_item(OP_DATA, "b"); push_item(OP_DATA, "c");
    push_item(OP_DATA, "a"); push_item(OP_DATA, "b"); push_item(OP_DATA, "a");
    push_item(OP_DATA, "a"); push_item(OP_END, 8'hFF);
    push_item(OP_END, 8'h00);
    push_item(OP_DATA, 8'h00); push_item(OP_DATA, 8'hFF);
    drain();

    // a register write drops the partial match; empty replacement removes the text
    push_item(OP_DATA, "a"); push_item(OP_DATA, "b");
    drain();
    write_reg(REG_REPLACE_LEN, 0);
    push_item(OP_END, 8'h55); push_item(OP_DATA, "c");
    push_item(OP_DATA, "a"); push_item(OP_DATA, "b"); push_item(OP_DATA, "c");
    drain();

    // line prefix; line state survives a detour through search mode
    write_reg(REG_SEARCH_LEN, 0);
    write_reg(REG_REPLACE_TEXT, 64'h203E);
    write_reg(REG_REPLACE_LEN, 2);
    push_item(OP_DATA, "h"); push_item(OP_DATA, NEWLINE_BYTE); push_item(OP_DATA, "x");
    drain();
    write_reg(REG_SEARCH_LEN, 1);
    push_item(OP_DATA, "q");
    drain();
    write_reg(REG_SEARCH_LEN, 0);
    push_item(OP_DATA, "z"); push_item(OP_DATA, NEWLINE_BYTE);
    push_item(OP_DATA, "w"); push_item(OP_END, 8'hAA);
    drain();

    random_phase(32, 1, 1, 64'({$urandom, $urandom}), 64'({$urandom, $urandom}), 1'b0);
    random_phase(32, 8, 8, 64'({$urandom, $urandom}), 64'({$urandom, $urandom}), 1'b1);
    random_phase(32, 0, 8, 64'({$urandom, $urandom}), 64'({$urandom, $urandom}), 1'b0);
    random_phase(32, 15, 15, '1, '0, 1'b0);
    random_phase(32, 3, 0, 64'({$urandom, $urandom}), 64'({$urandom, $urandom}), 1'b0);
    random_phase(32, 0, 0, '0, '1, 1'b0);
    random_phase(32, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                 64'({$urandom, $urandom}), 64'({$urandom, $urandom}), 1'b0);
    random_phase(32, 4'($urandom_range(1, 4)), 4'($urandom_range(0, 9)),
                 64'({$urandom, $urandom}), 64'({$urandom, $urandom}), 1'b0);

    drain();
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ssrf_pkg.sv
rtl/ssrf_in_if.sv
rtl/ssrf_out_if.sv
rtl/ssrf_front.sv
rtl/ssrf_queue.sv
rtl/ssrf_back.sv
rtl/stream_search_replace_filter_core.sv
tb/testbench.sv
